>>> rtl/pcsp_pkg.sv
// Shared types and constants for the patch chunk stream parser.
// No dependencies; imported by every module of the block.
package pcsp_pkg;

    // Fixed layout of one chunk header: offset, size, flags, 4 bytes each
    localparam int unsigned CHUNK_HDR_LEN = 12;
    localparam logic [3:0]  CHUNK_HDR_LAST = 4'd11;

    // Byte kinds on the result beat
    localparam logic [1:0] KIND_OTHER   = 2'd0;
    localparam logic [1:0] KIND_OLD_SUM = 2'd1;
    localparam logic [1:0] KIND_NEW_SUM = 2'd2;
    localparam logic [1:0] KIND_DATA    = 2'd3;

    // Status codes, sticky until the next file starts
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TOO_SMALL = 3'd1;
    localparam logic [2:0] ST_BAD_SIG   = 3'd2;
    localparam logic [2:0] ST_OVERRUN   = 3'd3;
    localparam logic [2:0] ST_MISMATCH  = 3'd4;
    localparam logic [2:0] ST_TRUNCATED = 3'd5;

    // Parse phase
    typedef enum logic [2:0] {
        PH_FILE_HDR  = 3'b001,
        PH_CHUNK_HDR = 3'b010,
        PH_DATA      = 3'b100
    } phase_t;

    // One result beat
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload;
        logic [32:0] addr;
        logic        chunk_end;
        logic [2:0]  status;
        logic        done;
    } result_t;

    // Signature "DfuP", byte by byte
    function automatic logic [7:0] sig_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h44;
            2'd1:    b = 8'h66;
            2'd2:    b = 8'h75;
            default: b = 8'h50;
        endcase
        return b;
    endfunction

endpackage

>>> rtl/patch_chunk_stream_parser.sv
// Patch chunk stream parser, top level.
// Depends on pcsp_pkg, pcsp_parse_core and pcsp_out_reg.
//
// Takes a patch file one byte per beat and gives exactly one result beat per
// input beat, in the cycle after the byte is taken: header, checksum and chunk
// data bytes tagged with their kind and address, plus a sticky status and an
// end-of-file flag. Write file_length through cfg_we/cfg_wdata before each
// file; the write clears all parse state. Throughput is one byte per cycle;
// the only loop is the byte counter, phase, status and chunk field registers,
// updated in the same cycle a byte is taken. The input stalls only while a
// result waits in the output register and the output side is stalling.
module patch_chunk_stream_parser
    import pcsp_pkg::*;
#(
    parameter int unsigned CHECKSUM_BYTES = 20
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  file_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  byte_kind,
    output logic [7:0]  payload_byte,
    output logic [32:0] target_address,
    output logic        chunk_end,
    output logic [2:0]  status,
    output logic        done_res
);

    logic    in_accept;
    logic    busy;
    result_t res_core;
    result_t res_q;

    assign in_stall  = busy;
    assign in_accept = in_valid && !busy;

    pcsp_parse_core #(
        .CHECKSUM_BYTES (CHECKSUM_BYTES)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_accept (in_accept),
        .file_byte (file_byte),
        .res       (res_core)
    );

    pcsp_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_accept),
        .res_in    (res_core),
        .out_stall (out_stall),
        .busy      (busy),
        .out_valid (out_valid),
        .res_out   (res_q)
    );

    assign byte_kind      = res_q.kind;
    assign payload_byte   = res_q.payload;
    assign target_address = res_q.addr;
    assign chunk_end      = res_q.chunk_end;
    assign status         = res_q.status;
    assign done_res       = res_q.done;

endmodule

>>> rtl/pcsp_parse_core.sv
// Parser state and per-byte decode for the patch chunk stream parser.
// Depends on pcsp_pkg; produces one result_t per accepted byte.
module pcsp_parse_core
    import pcsp_pkg::*;
#(
    parameter int unsigned CHECKSUM_BYTES = 20
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        in_accept,
    input  logic [7:0]  file_byte,
    output result_t     res
);

    localparam logic [31:0] SUM_LEN      = 32'(CHECKSUM_BYTES);
    localparam logic [31:0] FILE_HDR_LEN = 32'(8 + 2 * CHECKSUM_BYTES);
    localparam logic [31:0] MIN_FILE_LEN = 32'(8 + 2 * CHECKSUM_BYTES + CHUNK_HDR_LEN + 1);

    logic [31:0] flen_reg;
    logic [31:0] pos_reg,   pos_next;
    phase_t      phase_reg, phase_next;
    logic [3:0]  idx_reg,   idx_next;
    logic [31:0] start_reg, start_next;
    logic [31:0] off_reg,   off_next;
    logic [31:0] size_reg,  size_next;
    logic [31:0] seen_reg,  seen_next;
    logic [2:0]  err_reg,   err_next;

    logic [31:0] seen_inc;
    logic [32:0] st_sz;
    logic [32:0] st_hdr_sz;
    logic [31:0] left;

    // Per-byte decode
    always_comb
    begin
        pos_next   = pos_reg;
        phase_next = phase_reg;
        idx_next   = idx_reg;
        start_next = start_reg;
        off_next   = off_reg;
        size_next  = size_reg;
        seen_next  = seen_reg;
        err_next   = err_reg;
        res        = '0;

        seen_inc  = seen_reg + 32'd1;
        st_sz     = {1'b0, start_reg} + {1'b0, size_reg};
        st_hdr_sz = st_sz + 33'(CHUNK_HDR_LEN);
        left      = flen_reg - pos_reg;

        // file too short for even one header and one data byte
        if (err_reg == ST_OK && flen_reg < MIN_FILE_LEN)
        begin
            err_next = ST_TOO_SMALL;
        end

        if (pos_reg < flen_reg)
        begin
            res.done = ({1'b0, pos_reg} + 33'd1) == {1'b0, flen_reg};
            pos_next = pos_reg + 32'd1;

            if (err_next == ST_OK)
            begin
                case (phase_reg)
                    PH_FILE_HDR:
                    begin
                        if (pos_reg < 32'd4)
                        begin
                            if (file_byte != sig_byte(pos_reg[1:0]))
                            begin
                                err_next = ST_BAD_SIG;
                            end
                        end
                        else if (pos_reg >= 32'd8 && pos_reg < 32'd8 + SUM_LEN)
                        begin
                            res.kind    = KIND_OLD_SUM;
                            res.payload = file_byte;
                            res.addr    = {1'b0, pos_reg - 32'd8};
                        end
                        else if (pos_reg >= 32'd8 + SUM_LEN)
                        begin
                            res.kind    = KIND_NEW_SUM;
                            res.payload = file_byte;
                            res.addr    = {1'b0, pos_reg - 32'd8 - SUM_LEN};
                        end
                        if (err_next == ST_OK && pos_reg >= FILE_HDR_LEN - 32'd1)
                        begin
                            phase_next = PH_CHUNK_HDR;
                            idx_next   = 4'd0;
                        end
                    end

                    PH_CHUNK_HDR:
                    begin
                        if (idx_reg == 4'd0 && left < 32'(CHUNK_HDR_LEN))
                        begin
                            err_next = ST_TRUNCATED;
                        end
                        else
                        begin
                            // little-endian fields, cleared at the first header byte
                            case (idx_reg)
                                4'd0:
                                begin
                                    start_next = pos_reg;
                                    off_next   = {24'd0, file_byte};
                                    size_next  = '0;
                                end
                                4'd1:    off_next[15:8]   = file_byte;
                                4'd2:    off_next[23:16]  = file_byte;
                                4'd3:    off_next[31:24]  = file_byte;
                                4'd4:    size_next[7:0]   = file_byte;
                                4'd5:    size_next[15:8]  = file_byte;
                                4'd6:    size_next[23:16] = file_byte;
                                4'd7:    size_next[31:24] = file_byte;
                                default: ;
                            endcase

                            if (idx_reg >= CHUNK_HDR_LAST)
                            begin
                                idx_next = 4'd0;
                                if (size_reg > flen_reg || st_sz > {1'b0, flen_reg})
                                begin
                                    err_next = ST_OVERRUN;
                                end
                                else if (st_hdr_sz > {1'b0, flen_reg})
                                begin
                                    err_next = ST_MISMATCH;
                                end
                                else if (size_reg != 32'd0)
                                begin
                                    phase_next = PH_DATA;
                                    seen_next  = '0;
                                end
                            end
                            else
                            begin
                                idx_next = idx_reg + 4'd1;
                            end
                        end
                    end

                    PH_DATA:
                    begin
                        res.kind    = KIND_DATA;
                        res.payload = file_byte;
                        res.addr    = {1'b0, off_reg} + {1'b0, seen_reg};
                        seen_next   = seen_inc;
                        if (seen_inc >= size_reg)
                        begin
                            res.chunk_end = 1'b1;
                            phase_next    = PH_CHUNK_HDR;
                            idx_next      = 4'd0;
                        end
                    end

                    default: ;
                endcase
            end
        end

        res.status = err_next;
    end

    // State registers; a length write starts a new file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flen_reg  <= '0;
            pos_reg   <= '0;
            phase_reg <= PH_FILE_HDR;
            idx_reg   <= '0;
            start_reg <= '0;
            off_reg   <= '0;
            size_reg  <= '0;
            seen_reg  <= '0;
            err_reg   <= ST_OK;
        end
        else if (cfg_we)
        begin
            flen_reg  <= cfg_wdata;
            pos_reg   <= '0;
            phase_reg <= PH_FILE_HDR;
            idx_reg   <= '0;
            start_reg <= '0;
            off_reg   <= '0;
            size_reg  <= '0;
            seen_reg  <= '0;
            err_reg   <= ST_OK;
        end
        else if (in_accept)
        begin
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            start_reg <= start_next;
            off_reg   <= off_next;
            size_reg  <= size_next;
            seen_reg  <= seen_next;
            err_reg   <= err_next;
        end
    end

endmodule

>>> rtl/pcsp_out_reg.sv
// Result register of the patch chunk stream parser: holds one result beat
// until the downstream side takes it. Depends on pcsp_pkg.
module pcsp_out_reg
    import pcsp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t res_in,
    input  logic    out_stall,
    output logic    busy,
    output logic    out_valid,
    output result_t res_out
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    // Full and not being taken this cycle
    assign busy = valid_reg && out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (valid_reg && !out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = data_reg;

endmodule
